>>> hw/rtl/dbf_pkg.sv
// Shared types, constants and the CRC step for the download block framer.
// No dependencies; imported by every module of the framer.
`timescale 1ns / 1ps

package dbf_pkg;

	// Default sizing
	localparam int TABLE_BYTES_DEF      = 124;
	localparam int MESSAGE_CAPACITY_DEF = 64;

	// Service identifiers
	localparam logic [7:0] SID_TRANSFER_DATA = 8'h36;
	localparam logic [7:0] SID_TRANSFER_EXIT = 8'h37;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] DEFAULT_BLOCK = 8'd16;
	localparam logic [7:0] COUNTER_INIT  = 8'd1;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Message kinds on the output tuser
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EXIT = 1'b1;

	// One classified input byte, handed from front to back
	typedef struct packed {
		logic [7:0]  data;      // table byte
		logic [7:0]  counter;   // block counter of its message
		logic        header;    // byte opens a new message
		logic        blk_end;   // byte closes its transfer message
		logic        tbl_end;   // byte is the last of the table
		logic [15:0] crc;       // running CRC including this byte
	} dbf_entry_t;

	// Output sequencer position
	typedef enum logic [2:0] {
		PH_SID,
		PH_CNT,
		PH_DATA,
		PH_XSID,
		PH_XLO,
		PH_XHI
	} dbf_phase_t;

	// One byte through the CRC, MSB first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/dbf_front.sv
// Front end of the framer: takes table bytes, runs the CRC and the block and table
// counters, and tags each byte for the back end. Depends on dbf_pkg.
`timescale 1ns / 1ps

module dbf_front import dbf_pkg::*; #(
	parameter int TABLE_BYTES      = TABLE_BYTES_DEF,
	parameter int MESSAGE_CAPACITY = MESSAGE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	input  logic       queue_full,
	output logic       push,
	output dbf_entry_t entry
);

	localparam int         ROOM_INT = MESSAGE_CAPACITY - 2;
	localparam logic [7:0] ROOM     = 8'(ROOM_INT);
	localparam logic [7:0] DEF_EFF  = (16 > ROOM_INT) ? ROOM : DEFAULT_BLOCK;
	localparam logic [15:0] LAST_IDX = 16'(TABLE_BYTES);

	logic [7:0]  block_length_q;
	logic [15:0] crc_q;
	logic [7:0]  counter_q;
	logic [7:0]  bib_q;
	logic [15:0] bit_q;

	logic [7:0]  eff;
	logic [15:0] crc_n;
	logic [7:0]  bib_inc;
	logic [15:0] bit_inc;
	logic        last_tbl;
	logic        last_blk;

	// Effective block length
	assign eff = (block_length_q == 8'd0 || block_length_q > ROOM) ? DEF_EFF : block_length_q;

	// Classification of the incoming byte
	assign crc_n    = crc_update(crc_q, in_data);
	assign bib_inc  = bib_q + 8'd1;
	assign bit_inc  = bit_q + 16'd1;
	assign last_tbl = bit_inc >= LAST_IDX;
	assign last_blk = last_tbl || bib_inc >= eff || bib_inc == 8'd0;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		entry.data    = in_data;
		entry.counter = counter_q;
		entry.header  = (bib_q == 8'd0);
		entry.blk_end = last_blk;
		entry.tbl_end = last_tbl;
		entry.crc     = crc_n;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= DEFAULT_BLOCK;
		end else if (cfg_valid) begin
			block_length_q <= cfg_data;
		end
	end

	// Framing state, cleared at the end of each table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			counter_q <= COUNTER_INIT;
			bib_q     <= 8'd0;
			bit_q     <= 16'd0;
		end else if (push) begin
			if (last_tbl) begin
				crc_q     <= CRC_INIT;
				counter_q <= COUNTER_INIT;
				bib_q     <= 8'd0;
				bit_q     <= 16'd0;
			end else begin
				crc_q <= crc_n;
				bit_q <= bit_inc;
				if (last_blk) begin
					bib_q     <= 8'd0;
					counter_q <= counter_q + 8'd1;
				end else begin
					bib_q <= bib_inc;
				end
			end
		end
	end

endmodule

>>> hw/rtl/dbf_queue.sv
// Short queue of tagged bytes between the framer front and back ends.
// Depends on dbf_pkg.
`timescale 1ns / 1ps

module dbf_queue import dbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  dbf_entry_t wr_entry,
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output dbf_entry_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

	dbf_entry_t    slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == DEPTH_C);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/dbf_back.sv
// Back end of the framer: expands each tagged byte into message bytes (header,
// data, exit message) through a registered output stage. Depends on dbf_pkg.
`timescale 1ns / 1ps

module dbf_back import dbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  dbf_entry_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_end,
	output logic       out_kind,
	output logic       out_tend
);

	dbf_phase_t phase_q;
	dbf_phase_t phase_d;
	dbf_phase_t cur;
	logic       advance;
	logic       last_byte;

	logic [7:0] byte_d;
	logic       end_d;
	logic       kind_d;
	logic       tend_d;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;
	logic       out_kind_q;
	logic       out_tend_q;

	// A byte without header skips straight to its data
	assign cur = (phase_q == PH_SID && !head.header) ? PH_DATA : phase_q;

	assign advance   = head_valid && (!out_valid_q || out_ready);
	assign last_byte = (cur == PH_DATA && !head.tbl_end) || cur == PH_XHI;
	assign pop       = advance && last_byte;

	// Next position
	always_comb begin
		phase_d = phase_q;
		if (advance) begin
			unique case (cur)
				PH_SID:  phase_d = PH_CNT;
				PH_CNT:  phase_d = PH_DATA;
				PH_DATA: phase_d = head.tbl_end ? PH_XSID : PH_SID;
				PH_XSID: phase_d = PH_XLO;
				PH_XLO:  phase_d = PH_XHI;
				PH_XHI:  phase_d = PH_SID;
				default: phase_d = PH_SID;
			endcase
		end
	end

	// Byte for the current position
	always_comb begin
		byte_d = SID_TRANSFER_DATA;
		end_d  = 1'b0;
		kind_d = KIND_DATA;
		tend_d = 1'b0;
		unique case (cur)
			PH_SID:  byte_d = SID_TRANSFER_DATA;
			PH_CNT:  byte_d = head.counter;
			PH_DATA: begin
				byte_d = head.data;
				end_d  = head.blk_end;
			end
			PH_XSID: begin
				byte_d = SID_TRANSFER_EXIT;
				kind_d = KIND_EXIT;
			end
			PH_XLO:  begin
				byte_d = head.crc[7:0];
				kind_d = KIND_EXIT;
			end
			PH_XHI:  begin
				byte_d = head.crc[15:8];
				end_d  = 1'b1;
				kind_d = KIND_EXIT;
				tend_d = 1'b1;
			end
			default: byte_d = SID_TRANSFER_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SID;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			out_end_q  <= end_d;
			out_kind_q <= kind_d;
			out_tend_q <= tend_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_end   = out_end_q;
	assign out_kind  = out_kind_q;
	assign out_tend  = out_tend_q;

endmodule

>>> hw/rtl/download_block_framer_crc16.sv
// Download block framer: cuts a table of TABLE_BYTES bytes into TransferData messages
// (0x36, block counter from 1, up to block_length data bytes) and closes it with a
// TransferExit message (0x37, CRC-16/CCITT-FALSE low then high byte). The front end
// takes one table byte per cycle while the two-entry queue has room; the back end
// puts out one message byte per cycle while the receiver is ready, so each message
// header and the table's exit message add output bytes. The output port's one byte
// per cycle sets the sustained rate. block_length may only be written while idle.
// Depends on dbf_pkg, dbf_front, dbf_queue, dbf_back.
`timescale 1ns / 1ps

module download_block_framer_crc16 import dbf_pkg::*; #(
	parameter int TABLE_BYTES      = TABLE_BYTES_DEF,
	parameter int MESSAGE_CAPACITY = MESSAGE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: block_length
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] message_byte
	output logic       m_tlast,   // message_end
	output logic [1:0] m_tuser    // [0] message_kind, [1] table_end
);

	logic       push;
	logic       pop;
	logic       full;
	logic       not_empty;
	dbf_entry_t wr_entry;
	dbf_entry_t head;

	assign cfg_ready = 1'b1;

	dbf_front #(
		.TABLE_BYTES      (TABLE_BYTES),
		.MESSAGE_CAPACITY (MESSAGE_CAPACITY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.queue_full (full),
		.push       (push),
		.entry      (wr_entry)
	);

	dbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	dbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_end    (m_tlast),
		.out_kind   (m_tuser[0]),
		.out_tend   (m_tuser[1])
	);

endmodule

>>> verif/tb_download_block_framer_crc16.sv
// Testbench for download_block_framer_crc16: drives table bytes, predicts every message byte
// (headers, data, exit with CRC-16) and checks the output stream byte by byte.
// Depends on dbf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_download_block_framer_crc16;
	import dbf_pkg::*;

	localparam int TABLE_LEN   = TABLE_BYTES_DEF;
	localparam int BLOCK_ROOM  = MESSAGE_CAPACITY_DEF - 2;
	localparam int LONG_STALL  = 150;
	localparam int STUCK_LIMIT = 2000;

	// one expected output byte
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       kind;
		logic       tend;
	} msg_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] data_byte
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [7:0] message_byte
	logic       m_tlast;    // message_end
	logic [1:0] m_tuser;    // [0] message_kind, [1] table_end

	// framer state as predicted
	logic [7:0]  blk_len_reg;
	logic [15:0] crc_acc;
	logic [7:0]  blk_cnt;
	logic [7:0]  blk_fill;
	logic [15:0] tbl_fill;

	msg_byte_t msg_due_q[$];
	int        mismatches;
	int        src_idle_pct;
	int        sink_idle_pct;
	int        stall_req;
	int        stall_done;

	download_block_framer_crc16 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	// CRC-16/CCITT-FALSE, one input bit per iteration, MSB first
	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	// block length actually used: 0 or over capacity falls back to the default
	function automatic int eff_block_len();
		int len;
		len = int'(blk_len_reg);
		if (len == 0 || len > BLOCK_ROOM)
			len = int'(DEFAULT_BLOCK);
		if (len > BLOCK_ROOM)
			len = BLOCK_ROOM;
		return len;
	endfunction

	task automatic clear_framing();
		crc_acc  = CRC_INIT;
		blk_cnt  = COUNTER_INIT;
		blk_fill = '0;
		tbl_fill = '0;
	endtask

	task automatic queue_msg_byte(input logic [7:0] d, input logic l, input logic k,
	                              input logic t);
		msg_byte_t mb;
		mb.data = d;
		mb.last = l;
		mb.kind = k;
		mb.tend = t;
		msg_due_q.push_back(mb);
	endtask

	// all output bytes caused by one accepted table byte
	task automatic frame_table_byte(input logic [7:0] b);
		int   lim;
		logic tbl_done;
		logic blk_done;
		lim = eff_block_len();
		if (blk_fill == 0) begin
			queue_msg_byte(SID_TRANSFER_DATA, 1'b0, KIND_DATA, 1'b0);
			queue_msg_byte(blk_cnt, 1'b0, KIND_DATA, 1'b0);
		end
		crc_acc  = crc16_next(crc_acc, b);
		blk_fill = blk_fill + 8'd1;
		tbl_fill = tbl_fill + 16'd1;
		tbl_done = (tbl_fill >= TABLE_LEN);
		blk_done = tbl_done || (blk_fill >= lim) || (blk_fill == 0);
		queue_msg_byte(b, blk_done, KIND_DATA, 1'b0);
		if (blk_done) begin
			blk_fill = '0;
			blk_cnt  = blk_cnt + 8'd1;
		end
		if (tbl_done) begin
			queue_msg_byte(SID_TRANSFER_EXIT, 1'b0, KIND_EXIT, 1'b0);
			queue_msg_byte(crc_acc[7:0], 1'b0, KIND_EXIT, 1'b0);
			queue_msg_byte(crc_acc[15:8], 1'b1, KIND_EXIT, 1'b1);
			clear_framing();
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : check_output
		msg_byte_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (msg_due_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", m_tdata));
			end else begin
				due = msg_due_q.pop_front();
				if (m_tdata !== due.data)
					report_mismatch($sformatf("byte %02h, want %02h", m_tdata, due.data));
				if (m_tlast !== due.last)
					report_mismatch($sformatf("tlast %b, want %b on byte %02h",
						m_tlast, due.last, due.data));
				if (m_tuser[0] !== due.kind)
					report_mismatch($sformatf("kind %b, want %b on byte %02h",
						m_tuser[0], due.kind, due.data));
				if (m_tuser[1] !== due.tend)
					report_mismatch($sformatf("table_end %b, want %b on byte %02h",
						m_tuser[1], due.tend, due.data));
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// random stalls, plus one long hold-off when a test asks for it
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req != stall_done) begin
				stall_done = stall_req;
				hold       = LONG_STALL;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
			    || !arst_n)
				stuck = 0;
			else
				stuck++;
		end
		$display("tb_download_block_framer_crc16: errors");
		$finish;
	end

	// ---------------------------------------------------------------- drivers

	// offer one table byte; valid stays up for a following byte
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		frame_table_byte(b);
	endtask

	// stop offering and wait until every predicted byte has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (msg_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_block_length(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		blk_len_reg  = v;
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// ---------------------------------------------------------------- tests

	// data byte extremes and alternating patterns at the default length
	task automatic test_data_extremes();
		write_block_length(DEFAULT_BLOCK);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h55);
		send_byte(8'hAA);
		drain();
	endtask

	// shortest length, zero, over capacity, largest, then a shrink mid-message
	task automatic test_block_lengths();
		write_block_length(8'd1);
		repeat (3) send_byte(8'($urandom_range(0, 255)));
		drain();
		write_block_length(8'd0);
		repeat (2) send_byte(8'($urandom_range(0, 255)));
		drain();
		write_block_length(8'd255);
		send_byte(8'($urandom_range(0, 255)));
		drain();
		write_block_length(8'(BLOCK_ROOM + 1));
		send_byte(8'($urandom_range(0, 255)));
		drain();
		write_block_length(8'(BLOCK_ROOM));
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		drain();
		// open message already holds more than the new length: next byte closes it
		write_block_length(8'd2);
		repeat (3) send_byte(8'($urandom_range(0, 255)));
		drain();
	endtask

	// random bytes in bursts, block length changed between bursts
	task automatic test_random_tables(input int n_items);
		int burst;
		logic [7:0] len;
		while (n_items > 0) begin
			burst = $urandom_range(10, 60);
			if (burst > n_items)
				burst = n_items;
			repeat (burst) send_byte(8'($urandom_range(0, 255)));
			n_items -= burst;
			drain();
			case ($urandom_range(0, 7))
				0: len = 8'd0;
				1: len = 8'd1;
				2: len = 8'd2;
				3: len = 8'(BLOCK_ROOM);
				4: len = 8'(BLOCK_ROOM + 1);
				5: len = 8'd255;
				6: len = DEFAULT_BLOCK;
				default: len = 8'($urandom_range(0, 255));
			endcase
			write_block_length(len);
		end
	endtask

	// receiver holds off long enough for the framer to fill and stall its input
	task automatic test_backpressure();
		set_idling(0, 0);
		stall_req++;
		repeat (30) send_byte(8'($urandom_range(0, 255)));
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		mismatches    = 0;
		stall_req     = 0;
		stall_done    = 0;
		blk_len_reg   = DEFAULT_BLOCK;
		set_idling(0, 0);
		clear_framing();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_data_extremes();
		test_block_lengths();
		set_idling(34, 88);
		test_random_tables(100);
		set_idling(88, 34);
		test_random_tables(100);
		set_idling(0, 0);
		test_random_tables(100);
		test_backpressure();

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && msg_due_q.size() == 0)
			$display("tb_download_block_framer_crc16: clean");
		else
			$display("tb_download_block_framer_crc16: errors");
		$finish;
	end

endmodule

>>> download_block_framer_crc16.f
hw/rtl/dbf_pkg.sv
hw/rtl/dbf_front.sv
hw/rtl/dbf_queue.sv
hw/rtl/dbf_back.sv
hw/rtl/download_block_framer_crc16.sv
verif/tb_download_block_framer_crc16.sv
